// File: sv/tabular_q_learning_agent_macros.svh
// assertion macros shared by the checker of the q-learning agent
`ifndef TABULAR_Q_LEARNING_AGENT_MACROS_SVH
`define TABULAR_Q_LEARNING_AGENT_MACROS_SVH

// property checked on the rising edge, held off while reset is asserted
`define TQLA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every rising edge, reset included
`define TQLA_ASSERT_ON(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/tqla_pkg.sv
// shared constants, types and market binning for the q-learning agent
package tqla_pkg;

    // sizing
    localparam int STATE_COUNT      = 28;
    localparam int PRICE_BANDS      = 7;
    localparam int HOURS_DEF        = 24;
    localparam int ACTION_COUNT_DEF = 3;
    localparam int VALUE_WIDTH_DEF  = 32;

    // field widths
    localparam int HOUR_W     = 5;
    localparam int LOAD_W     = 18;
    localparam int PRICE_W    = 15;
    localparam int REWARD_W   = 32;
    localparam int RAND_W     = 2;
    localparam int ACTION_W   = 2;
    localparam int MSTATE_W   = 5;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEARNING_RATE = 2'd0,
        CFG_DISCOUNT      = 2'd1,
        CFG_TIE_MARGIN    = 2'd2
    } cfg_idx_t;

    // register reset values
    localparam logic [CFG_W-1:0] LEARNING_RATE_RST = 16'd13107;
    localparam logic [CFG_W-1:0] DISCOUNT_RST      = 16'd45875;
    localparam logic [CFG_W-1:0] TIE_MARGIN_RST    = 16'd66;

    // load limits in MW with 4 fraction bits
    localparam logic [LOAD_W-1:0] LOAD_LO = 18'd64000;
    localparam logic [LOAD_W-1:0] LOAD_B1 = 18'd79984;
    localparam logic [LOAD_W-1:0] LOAD_B2 = 18'd95984;
    localparam logic [LOAD_W-1:0] LOAD_B3 = 18'd111984;
    localparam logic [LOAD_W-1:0] LOAD_HI = 18'd136000;

    // price limits with 8 fraction bits
    localparam logic [PRICE_W-1:0] PRICE_S1  = 15'd1280;
    localparam logic [PRICE_W-1:0] PRICE_S2  = 15'd2560;
    localparam logic [PRICE_W-1:0] PRICE_S3  = 15'd3840;
    localparam logic [PRICE_W-1:0] PRICE_S4  = 15'd5120;
    localparam logic [PRICE_W-1:0] PRICE_S5  = 15'd6400;
    localparam logic [PRICE_W-1:0] PRICE_MLO = 15'd12800;
    localparam logic [PRICE_W-1:0] PRICE_MHI = 15'd15360;
    localparam logic [PRICE_W-1:0] PRICE_TOP = 15'd17920;

    typedef struct packed {
        logic                ok;
        logic [MSTATE_W-1:0] state;
    } bin_t;

    // load band times seven plus price band, ok low when either falls outside
    function automatic bin_t market_bin(input logic [LOAD_W-1:0]  load,
                                        input logic [PRICE_W-1:0] price);
        logic       lok;
        logic       pok;
        logic [1:0] lb;
        logic [2:0] pb;
        bin_t       b;
        lok = 1'b1;
        lb  = 2'd0;
        if (load < LOAD_LO) lok = 1'b0;
        else if (load <= LOAD_B1) lb = 2'd0;
        else if (load <= LOAD_B2) lb = 2'd1;
        else if (load <= LOAD_B3) lb = 2'd2;
        else if (load <= LOAD_HI) lb = 2'd3;
        else lok = 1'b0;
        pok = 1'b1;
        pb  = 3'd0;
        if (price <= PRICE_S1) pb = 3'd0;
        else if (price <= PRICE_S2) pb = 3'd1;
        else if (price <= PRICE_S3) pb = 3'd2;
        else if (price <= PRICE_S4) pb = 3'd3;
        else if (price <= PRICE_S5) pb = 3'd4;
        else if (price >= PRICE_MLO && price <= PRICE_MHI) pb = 3'd5;
        else if (price > PRICE_MHI && price <= PRICE_TOP) pb = 3'd6;
        else pok = 1'b0;
        b.ok    = lok & pok;
        b.state = b.ok ? MSTATE_W'(MSTATE_W'(lb) * MSTATE_W'(PRICE_BANDS) + MSTATE_W'(pb))
                       : '0;
        return b;
    endfunction

endpackage

// File: sv/tqla_ifs.sv
// valid/ready channels for input items and results
interface tqla_item_if;
    logic                                valid;
    logic                                ready;
    logic [tqla_pkg::HOUR_W-1:0]         hour;
    logic [tqla_pkg::LOAD_W-1:0]         load;
    logic [tqla_pkg::PRICE_W-1:0]        price;
    logic signed [tqla_pkg::REWARD_W-1:0] reward;
    logic                                explore;
    logic [tqla_pkg::RAND_W-1:0]         random_action;

    modport source (output valid, hour, load, price, reward, explore, random_action,
                    input ready);
    modport sink (input valid, hour, load, price, reward, explore, random_action,
                  output ready);
endinterface

interface tqla_result_if;
    logic                          valid;
    logic                          ready;
    logic [tqla_pkg::ACTION_W-1:0] action;
    logic [tqla_pkg::MSTATE_W-1:0] market_state;
    logic                          state_valid;

    modport source (output valid, action, market_state, state_valid, input ready);
    modport sink (input valid, action, market_state, state_valid, output ready);
endinterface

// File: sv/tqla_ram.sv
// generic simple dual-port ram with registered read
module tqla_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/tqla_fmul.sv
// fraction times value, rounded to nearest, in two partial products
module tqla_fmul #(
    parameter int VALUE_WIDTH = tqla_pkg::VALUE_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tqla_pkg::CFG_W-1:0]  frac,
    input  logic signed [VALUE_WIDTH:0] val,
    output logic                        done,
    output logic signed [VALUE_WIDTH+1:0] result
);

    localparam int V_W   = VALUE_WIDTH + 1;
    localparam int R_W   = VALUE_WIDTH + 2;
    localparam int LO_W  = (V_W + 1) / 2;
    localparam int OP_W  = LO_W + 1;
    localparam int P_W   = tqla_pkg::CFG_W + 1 + OP_W;
    localparam int ACC_W = tqla_pkg::CFG_W + 1 + V_W;
    localparam int FW    = tqla_pkg::CFG_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LO,
        ST_HI,
        ST_ACC,
        ST_RND
    } fm_state_t;

    fm_state_t               state_reg;
    logic [FW-1:0]           frac_reg;
    logic [V_W-1:0]          val_reg;
    logic signed [P_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [R_W-1:0]   res_reg;
    logic                    done_reg;

    logic signed [OP_W-1:0]  mult_op;
    logic signed [P_W-1:0]   prod_next;
    logic signed [ACC_W-1:0] rnd;

    // low half unsigned, high half signed
    assign mult_op = (state_reg == ST_LO) ? $signed({1'b0, val_reg[LO_W-1:0]})
                                          : OP_W'($signed(val_reg[V_W-1:LO_W]));
    assign prod_next = $signed({1'b0, frac_reg}) * mult_op;

    // add half an lsb before dropping the 16 fraction bits
    assign rnd = acc_reg + ACC_W'(32768);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            frac_reg  <= '0;
            val_reg   <= '0;
            prod_reg  <= '0;
            acc_reg   <= '0;
            res_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        frac_reg  <= frac;
                        val_reg   <= val;
                        state_reg <= ST_LO;
                    end
                end
                ST_LO:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= ST_HI;
                end
                ST_HI:
                begin
                    acc_reg   <= ACC_W'(prod_reg);
                    prod_reg  <= prod_next;
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    acc_reg   <= acc_reg + (ACC_W'(prod_reg) <<< LO_W);
                    state_reg <= ST_RND;
                end
                ST_RND:
                begin
                    res_reg   <= rnd[ACC_W-1:FW];
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// File: sv/tabular_q_learning_agent.sv
// Tabular Q-learning agent, one slice per market hour, epsilon-greedy action choice.
// Each accepted beat bins load and price into one of 28 market states, updates the
// hour's previous (state, action) value with Q16.16 arithmetic and returns one result
// beat carrying the next action. Values live in one value memory of
// HOURS*28*ACTION_COUNT entries and the per-hour state and action in a second small
// memory; both have a single registered read port. A greedy item makes two passes
// over the new state's action entries through the value memory read port plus two
// rounded products through the shared multiplier. An exploring item skips the
// rescan setup state and the second pass; an item with an unbinned load or price, or
// an hour out of range, goes straight to the done state and changes nothing. One item
// is in work at a time; the block is ready again once its result is loaded, and the
// next item is taken while a finished result waits. A result held by the sink stalls
// the item in work until the result register frees up.
// After reset a clearing pass over all HOURS*28*ACTION_COUNT entries (2016 at the
// defaults) zeroes the value memory before the first beat is taken; register writes
// are taken at any time.
module tabular_q_learning_agent #(
    parameter int HOURS        = tqla_pkg::HOURS_DEF,
    parameter int ACTION_COUNT = tqla_pkg::ACTION_COUNT_DEF,
    parameter int VALUE_WIDTH  = tqla_pkg::VALUE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tqla_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [tqla_pkg::CFG_W-1:0]     cfg_wdata,
    tqla_item_if.sink                      item,
    tqla_result_if.source                  result
);

    localparam int MS_W    = tqla_pkg::MSTATE_W;
    localparam int HA_W    = (HOURS > 1) ? $clog2(HOURS) : 1;
    localparam int AC_W    = $clog2(ACTION_COUNT);
    localparam int HM_W    = MS_W + AC_W;
    localparam int Q_DEPTH = HOURS * tqla_pkg::STATE_COUNT * ACTION_COUNT;
    localparam int QA_W    = $clog2(Q_DEPTH);
    localparam int V_W     = VALUE_WIDTH + 1;
    localparam int R_W     = VALUE_WIDTH + 2;
    localparam int S_W     = ((R_W > tqla_pkg::REWARD_W) ? R_W : tqla_pkg::REWARD_W) + 1;

    localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HOUR,
        S_SCAN,
        S_OLDQ,
        S_DISC,
        S_DIFF,
        S_ALPHA,
        S_RESCAN,
        S_DONE
    } agent_state_t;

    // clamp a wide sum to the signed value range
    function automatic logic signed [VALUE_WIDTH-1:0] sat_val(input logic signed [S_W-1:0] v);
        logic signed [VALUE_WIDTH-1:0] r;
        if (v > S_W'(VMAX)) r = VMAX;
        else if (v < S_W'(VMIN)) r = VMIN;
        else r = v[VALUE_WIDTH-1:0];
        return r;
    endfunction

    // configuration registers
    logic [tqla_pkg::CFG_W-1:0] alpha_reg;
    logic [tqla_pkg::CFG_W-1:0] gamma_reg;
    logic [tqla_pkg::CFG_W-1:0] margin_reg;

    // sequencer registers
    agent_state_t                   state_reg;
    logic [QA_W-1:0]                clr_reg;
    logic [tqla_pkg::HOUR_W-1:0]    hour_reg;
    logic [MS_W-1:0]                ns_reg;
    logic                           ok_reg;
    logic [QA_W-1:0]                ns_base_reg;
    logic [QA_W-1:0]                old_addr_reg;
    logic signed [tqla_pkg::REWARD_W-1:0] reward_reg;
    logic                           explore_reg;
    logic [AC_W-1:0]                ra_mod_reg;
    logic [AC_W-1:0]                scan_cnt_reg;
    logic                           pass_reg;
    logic signed [VALUE_WIDTH-1:0]  best_reg;
    logic [AC_W-1:0]                idx_reg;
    logic signed [VALUE_WIDTH-1:0]  oldq_reg;
    logic signed [VALUE_WIDTH-1:0]  target_reg;
    logic [AC_W-1:0]                act_reg;
    logic                           out_valid_reg;
    logic [tqla_pkg::ACTION_W-1:0]  out_action_reg;
    logic [MS_W-1:0]                out_state_reg;
    logic                           out_sv_reg;

    // memory and multiplier hookup
    logic                    q_we;
    logic [QA_W-1:0]         q_waddr;
    logic [VALUE_WIDTH-1:0]  q_wdata;
    logic [QA_W-1:0]         q_raddr;
    logic [VALUE_WIDTH-1:0]  q_rdata;
    logic                    hm_we;
    logic [HA_W-1:0]         hm_waddr;
    logic [HM_W-1:0]         hm_wdata;
    logic [HA_W-1:0]         hm_raddr;
    logic [HM_W-1:0]         hm_rdata;
    logic                    fm_start;
    logic [tqla_pkg::CFG_W-1:0] fm_frac;
    logic signed [V_W-1:0]   fm_val;
    logic                    fm_done;
    logic signed [R_W-1:0]   fm_result;

    // datapath
    tqla_pkg::bin_t                in_bin;
    logic                          in_ok;
    logic [QA_W-1:0]               in_ns_base;
    logic [AC_W-1:0]               in_ra_mod;
    logic [MS_W-1:0]               os_raw;
    logic [MS_W-1:0]               os_mod;
    logic [AC_W-1:0]               oa_raw;
    logic [AC_W-1:0]               oa_mod;
    logic [QA_W-1:0]               hour_old_addr;
    logic signed [VALUE_WIDTH-1:0] q_val;
    logic signed [V_W-1:0]         scan_diff;
    logic                          scan_take;
    logic signed [VALUE_WIDTH-1:0] best_next;
    logic [AC_W-1:0]               idx_next;
    logic                          scan_last;
    logic signed [S_W-1:0]         sum_target;
    logic signed [S_W-1:0]         sum_newq;
    logic signed [V_W-1:0]         diff_alpha;
    logic                          out_load;

    // register writes, indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg  <= tqla_pkg::LEARNING_RATE_RST;
            gamma_reg  <= tqla_pkg::DISCOUNT_RST;
            margin_reg <= tqla_pkg::TIE_MARGIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                tqla_pkg::CFG_LEARNING_RATE: alpha_reg  <= cfg_wdata;
                tqla_pkg::CFG_DISCOUNT:      gamma_reg  <= cfg_wdata;
                tqla_pkg::CFG_TIE_MARGIN:    margin_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // value memory and per-hour state/action memory
    tqla_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (Q_DEPTH),
        .AW    (QA_W)
    ) u_q_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    tqla_ram #(
        .WIDTH (HM_W),
        .DEPTH (HOURS),
        .AW    (HA_W)
    ) u_hour_ram (
        .clk   (clk),
        .we    (hm_we),
        .waddr (hm_waddr),
        .wdata (hm_wdata),
        .raddr (hm_raddr),
        .rdata (hm_rdata)
    );

    tqla_fmul #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_fmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (fm_start),
        .frac   (fm_frac),
        .val    (fm_val),
        .done   (fm_done),
        .result (fm_result)
    );

    // input beat decode
    assign in_bin     = tqla_pkg::market_bin(item.load, item.price);
    assign in_ok      = (32'(item.hour) < HOURS) && in_bin.ok;
    assign in_ns_base = QA_W'((32'(item.hour) * tqla_pkg::STATE_COUNT + 32'(in_bin.state))
                              * ACTION_COUNT);
    assign in_ra_mod  = (32'(item.random_action) >= ACTION_COUNT)
                        ? AC_W'(32'(item.random_action) - ACTION_COUNT)
                        : AC_W'(item.random_action);
    assign hm_raddr   = HA_W'(item.hour);

    // previous state and action of the hour, address of the entry to update
    assign os_raw = hm_rdata[HM_W-1:AC_W];
    assign oa_raw = hm_rdata[AC_W-1:0];
    assign os_mod = (os_raw >= MS_W'(tqla_pkg::STATE_COUNT))
                    ? os_raw - MS_W'(tqla_pkg::STATE_COUNT) : os_raw;
    assign oa_mod = ({1'b0, oa_raw} >= (AC_W+1)'(ACTION_COUNT))
                    ? AC_W'({1'b0, oa_raw} - (AC_W+1)'(ACTION_COUNT)) : oa_raw;
    assign hour_old_addr = QA_W'((32'(hour_reg) * tqla_pkg::STATE_COUNT + 32'(os_mod))
                                 * ACTION_COUNT + 32'(oa_mod));

    // best-value scan with the tie margin
    assign q_val     = $signed(q_rdata);
    assign scan_diff = V_W'(q_val) - V_W'(best_reg);
    assign scan_take = scan_diff > V_W'($signed({1'b0, margin_reg}));
    assign best_next = scan_take ? q_val : best_reg;
    assign idx_next  = scan_take ? scan_cnt_reg : idx_reg;
    assign scan_last = (scan_cnt_reg == AC_W'(ACTION_COUNT - 1));

    // target and updated value
    assign sum_target = S_W'(reward_reg) + S_W'(fm_result);
    assign sum_newq   = S_W'(oldq_reg) + S_W'(fm_result);
    assign diff_alpha = V_W'(target_reg) - V_W'(oldq_reg);

    // result register loads when the finished item finds it free
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || result.ready);

    // memory ports and multiplier operands per sequencer state
    always_comb
    begin
        q_we     = 1'b0;
        q_waddr  = old_addr_reg;
        q_wdata  = sat_val(sum_newq);
        q_raddr  = ns_base_reg;
        hm_we    = 1'b0;
        hm_waddr = HA_W'(hour_reg);
        hm_wdata = {ns_reg, idx_next};
        fm_start = 1'b0;
        fm_frac  = gamma_reg;
        fm_val   = V_W'(best_reg);
        case (state_reg)
            S_CLEAR:
            begin
                q_we     = 1'b1;
                q_waddr  = clr_reg;
                q_wdata  = '0;
                hm_we    = (32'(clr_reg) < HOURS);
                hm_waddr = HA_W'(clr_reg);
                hm_wdata = {MS_W'(1), AC_W'(0)};
            end
            S_SCAN:
            begin
                if (!scan_last)
                begin
                    q_raddr = ns_base_reg + QA_W'(scan_cnt_reg) + QA_W'(1);
                end
                else if (!pass_reg)
                begin
                    q_raddr = old_addr_reg;
                end
                else
                begin
                    hm_we = 1'b1;
                end
            end
            S_OLDQ:
            begin
                fm_start = 1'b1;
            end
            S_DIFF:
            begin
                fm_start = 1'b1;
                fm_frac  = alpha_reg;
                fm_val   = diff_alpha;
            end
            S_ALPHA:
            begin
                if (fm_done)
                begin
                    q_we = 1'b1;
                    if (explore_reg)
                    begin
                        hm_we    = 1'b1;
                        hm_wdata = {ns_reg, ra_mod_reg};
                    end
                end
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            hour_reg       <= '0;
            ns_reg         <= '0;
            ok_reg         <= 1'b0;
            ns_base_reg    <= '0;
            old_addr_reg   <= '0;
            reward_reg     <= '0;
            explore_reg    <= 1'b0;
            ra_mod_reg     <= '0;
            scan_cnt_reg   <= '0;
            pass_reg       <= 1'b0;
            best_reg       <= VMIN;
            idx_reg        <= '0;
            oldq_reg       <= '0;
            target_reg     <= '0;
            act_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_action_reg <= '0;
            out_state_reg  <= '0;
            out_sv_reg     <= 1'b0;
        end
        else
        begin
            // result valid: set on load, cleared when the sink takes the beat
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + QA_W'(1);
                    if (clr_reg == QA_W'(Q_DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (item.valid)
                    begin
                        hour_reg    <= item.hour;
                        ns_reg      <= in_bin.state;
                        ok_reg      <= in_ok;
                        ns_base_reg <= in_ns_base;
                        reward_reg  <= item.reward;
                        explore_reg <= item.explore;
                        ra_mod_reg  <= in_ra_mod;
                        state_reg   <= in_ok ? S_HOUR : S_DONE;
                    end
                end
                S_HOUR:
                begin
                    old_addr_reg <= hour_old_addr;
                    best_reg     <= VMIN;
                    idx_reg      <= '0;
                    scan_cnt_reg <= '0;
                    pass_reg     <= 1'b0;
                    state_reg    <= S_SCAN;
                end
                S_SCAN:
                begin
                    best_reg <= best_next;
                    idx_reg  <= idx_next;
                    if (!scan_last)
                    begin
                        scan_cnt_reg <= scan_cnt_reg + AC_W'(1);
                    end
                    else if (!pass_reg)
                    begin
                        state_reg <= S_OLDQ;
                    end
                    else
                    begin
                        act_reg   <= idx_next;
                        state_reg <= S_DONE;
                    end
                end
                S_OLDQ:
                begin
                    oldq_reg  <= q_val;
                    state_reg <= S_DISC;
                end
                S_DISC:
                begin
                    if (fm_done)
                    begin
                        target_reg <= sat_val(sum_target);
                        state_reg  <= S_DIFF;
                    end
                end
                S_DIFF:
                begin
                    state_reg <= S_ALPHA;
                end
                S_ALPHA:
                begin
                    if (fm_done)
                    begin
                        if (explore_reg)
                        begin
                            act_reg   <= ra_mod_reg;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_RESCAN;
                        end
                    end
                end
                S_RESCAN:
                begin
                    best_reg     <= VMIN;
                    idx_reg      <= '0;
                    scan_cnt_reg <= '0;
                    pass_reg     <= 1'b1;
                    state_reg    <= S_SCAN;
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        out_action_reg <= ok_reg ? tqla_pkg::ACTION_W'(act_reg) : '0;
                        out_state_reg  <= ok_reg ? ns_reg : '0;
                        out_sv_reg     <= ok_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // channel outputs
    assign item.ready          = (state_reg == S_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.action       = out_action_reg;
    assign result.market_state = out_state_reg;
    assign result.state_valid  = out_sv_reg;

endmodule

// File: sv/tqla_checker.sv
// port-level checks for the q-learning agent, bound to the top level
`include "tabular_q_learning_agent_macros.svh"

module tqla_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          item_valid,
    input logic                          item_ready,
    input logic                          result_valid,
    input logic                          result_ready,
    input logic [tqla_pkg::ACTION_W-1:0] action,
    input logic [tqla_pkg::MSTATE_W-1:0] market_state,
    input logic                          state_valid
);

    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       item_beat;
    logic       result_beat;

    assign item_beat   = item_valid & item_ready;
    assign result_beat = result_valid & result_ready;

    // items taken but not yet answered
    always_comb
    begin
        pending_next = pending_reg;
        if (item_beat && !result_beat)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (!item_beat && result_beat)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // a stalled result beat keeps its fields
    `TQLA_ASSERT(a_result_hold, clk, rst_n, result_valid && !result_ready |=> result_valid && $stable(action) && $stable(market_state) && $stable(state_valid), "result beat changed while stalled")

    // an unbinned or ignored item reports zeros
    `TQLA_ASSERT(a_invalid_zero, clk, rst_n, result_valid && !state_valid |-> action == '0 && market_state == '0, "invalid result carries nonzero fields")

    // market state stays inside the state table
    `TQLA_ASSERT(a_state_range, clk, rst_n, result_valid && state_valid |-> market_state < tqla_pkg::MSTATE_W'(tqla_pkg::STATE_COUNT), "market state out of range")

    // every result answers an accepted item
    `TQLA_ASSERT(a_no_spurious, clk, rst_n, result_beat |-> pending_reg != 2'd0, "result without an accepted item")

    // one item in work and one result waiting at most
    `TQLA_ASSERT_ON(a_pending_bound, clk, pending_reg <= 2'd2, "too many items outstanding")

endmodule

bind tabular_q_learning_agent tqla_checker u_tqla_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .action       (result.action),
    .market_state (result.market_state),
    .state_valid  (result.state_valid)
);

// File: tb/sv/tqla_bid_checker.sv
// result checker for the q-learning agent: predicts every result beat and compares it
module tqla_bid_checker
    import tqla_pkg::*;
#(
    parameter int HOURS   = HOURS_DEF,
    parameter int ACTIONS = ACTION_COUNT_DEF,
    parameter int VALUE_W = VALUE_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0]     cfg_wdata,
    tqla_item_if                 hour_ch,
    tqla_result_if               bid_ch,
    output int                   mismatches,
    output int                   awaited
);

    localparam int     Q_DEPTH   = HOURS * STATE_COUNT * ACTIONS;
    localparam longint VALUE_MAX = (longint'(1) << (VALUE_W - 1)) - 1;
    localparam longint VALUE_MIN = -VALUE_MAX - 1;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [MSTATE_W-1:0] market_state;
        logic                state_valid;
    } bid_t;

    // private copy of the agent: registers, value table and per-hour memory
    logic [CFG_W-1:0] alpha;
    logic [CFG_W-1:0] gamma;
    logic [CFG_W-1:0] margin;
    longint           q_values [Q_DEPTH];
    int               hour_state [HOURS];
    int               hour_action [HOURS];

    bid_t bids_due [$];
    bid_t want;
    int   slips = 0;

    assign mismatches = slips;

    function automatic longint clamp_value(input longint v);
        if (v > VALUE_MAX) return VALUE_MAX;
        if (v < VALUE_MIN) return VALUE_MIN;
        return v;
    endfunction

    // q0.16 fraction times q16.16 value, rounded half up, exact in 64 bits
    function automatic longint scale_frac(input logic [CFG_W-1:0] f, input longint v);
        longint fl;
        fl = f;
        return (fl * v + 32768) >>> 16;
    endfunction

    function automatic int load_band(input logic [LOAD_W-1:0] l);
        if (l < 4000 * 16) return -1;
        if (l <= 4999 * 16) return 0;
        if (l <= 5999 * 16) return 1;
        if (l <= 6999 * 16) return 2;
        if (l <= 8500 * 16) return 3;
        return -1;
    endfunction

    function automatic int price_band(input logic [PRICE_W-1:0] p);
        for (int b = 0; b < 5; b++)
            if (p <= (b + 1) * 5 * 256) return b;
        if (p >= 50 * 256 && p <= 60 * 256) return 5;
        if (p > 60 * 256 && p <= 70 * 256) return 6;
        return -1;
    endfunction

    // best value of one state, an entry wins only when it beats the best by more than margin
    function automatic void scan_values(input int base, output longint top, output int pick);
        top  = VALUE_MIN;
        pick = 0;
        for (int i = 0; i < ACTIONS; i++) begin
            if (q_values[base + i] - top > longint'(margin)) begin
                top  = q_values[base + i];
                pick = i;
            end
        end
    endfunction

    // one hour beat: learn on the previous pair, then pick the next bid action
    function automatic bid_t predict_bid(input logic [HOUR_W-1:0]          hr,
                                         input logic [LOAD_W-1:0]          ld,
                                         input logic [PRICE_W-1:0]         pr,
                                         input logic signed [REWARD_W-1:0] rw,
                                         input logic                       ex,
                                         input logic [RAND_W-1:0]          ra);
        bid_t   b;
        int     lb;
        int     pb;
        int     ns;
        int     base;
        int     old_k;
        int     pick;
        longint top;
        longint goal;
        longint prior;
        b = '0;
        if (hr >= HOURS) return b;
        lb = load_band(ld);
        pb = price_band(pr);
        if (lb < 0 || pb < 0) return b;
        ns   = lb * 7 + pb;
        base = (hr * STATE_COUNT + ns) * ACTIONS;
        scan_values(base, top, pick);
        goal  = clamp_value(longint'(rw) + scale_frac(gamma, top));
        old_k = (hr * STATE_COUNT + hour_state[hr]) * ACTIONS + hour_action[hr];
        prior = q_values[old_k];
        q_values[old_k] = clamp_value(prior + scale_frac(alpha, goal - prior));
        hour_state[hr] = ns;
        if (ex) pick = ra % ACTIONS;
        else scan_values(base, top, pick);
        hour_action[hr]  = pick;
        b.action         = pick[ACTION_W-1:0];
        b.market_state   = ns[MSTATE_W-1:0];
        b.state_valid    = 1'b1;
        return b;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            alpha  = LEARNING_RATE_RST;
            gamma  = DISCOUNT_RST;
            margin = TIE_MARGIN_RST;
            for (int i = 0; i < Q_DEPTH; i++) q_values[i] = 0;
            for (int h = 0; h < HOURS; h++) begin
                hour_state[h]  = 1;
                hour_action[h] = 0;
            end
            bids_due.delete();
            awaited <= 0;
        end else begin
            // register writes, spare index ignored
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_LEARNING_RATE: alpha  = cfg_wdata;
                    CFG_DISCOUNT:      gamma  = cfg_wdata;
                    CFG_TIE_MARGIN:    margin = cfg_wdata;
                    default: ;
                endcase
            end
            // result beat against the oldest prediction
            if (bid_ch.valid && bid_ch.ready) begin
                if (bids_due.size() == 0) begin
                    $error("result beat with no prediction waiting: action %0d state %0d",
                           bid_ch.action, bid_ch.market_state);
                    slips++;
                end else begin
                    want = bids_due.pop_front();
                    if (bid_ch.action !== want.action) begin
                        $error("action: expected %0d, got %0d", want.action, bid_ch.action);
                        slips++;
                    end
                    if (bid_ch.market_state !== want.market_state) begin
                        $error("market_state: expected %0d, got %0d",
                               want.market_state, bid_ch.market_state);
                        slips++;
                    end
                    if (bid_ch.state_valid !== want.state_valid) begin
                        $error("state_valid: expected %0d, got %0d",
                               want.state_valid, bid_ch.state_valid);
                        slips++;
                    end
                end
            end
            // hour beat into the predictor
            if (hour_ch.valid && hour_ch.ready)
                bids_due.push_back(predict_bid(hour_ch.hour, hour_ch.load, hour_ch.price,
                                               hour_ch.reward, hour_ch.explore,
                                               hour_ch.random_action));
            awaited <= bids_due.size();
        end
    end

endmodule

// File: tb/sv/tb_tabular_q_learning_agent.sv
// testbench top for the q-learning agent: stimulus, pacing, watchdog and verdict
module tb_tabular_q_learning_agent;

    localparam logic [tqla_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int STALL_LIMIT       = 10000;
    localparam int PHASES            = 5;
    localparam int ITEMS_PER_PHASE   = 265;
    localparam int TAIL_CYCLES       = 40;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [tqla_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [tqla_pkg::CFG_W-1:0]     cfg_wdata;
    logic                           steady;
    int                             offered;
    int                             mismatches;
    int                             awaited;

    tqla_item_if   hour_beats();
    tqla_result_if bid_beats();

    tabular_q_learning_agent i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .item      (hour_beats),
        .result    (bid_beats)
    );

    tqla_bid_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_wdata  (cfg_wdata),
        .hour_ch    (hour_beats),
        .bid_ch     (bid_beats),
        .mismatches (mismatches),
        .awaited    (awaited)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // result side stalls about a quarter of the cycles, never in the steady phase
    initial
    begin : bid_pacing
        bid_beats.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            bid_beats.ready <= steady || ($urandom_range(0, 99) >= 24);
        end
    end

    // ends the run once no beat has moved for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (hour_beats.valid && hour_beats.ready)
                       || (bid_beats.valid && bid_beats.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("no beat accepted for %0d cycles", STALL_LIMIT);
        $display("tb_tabular_q_learning_agent: FAIL");
        $finish;
    end

    // one hour beat, with a random gap ahead of it outside the steady phase
    task automatic offer(input logic [tqla_pkg::HOUR_W-1:0]          h,
                         input logic [tqla_pkg::LOAD_W-1:0]          l,
                         input logic [tqla_pkg::PRICE_W-1:0]         p,
                         input logic signed [tqla_pkg::REWARD_W-1:0] r,
                         input logic                                 e,
                         input logic [tqla_pkg::RAND_W-1:0]          a);
        while (!steady && $urandom_range(0, 99) < 24)
        begin
            hour_beats.valid <= 1'b0;
            @(posedge clk);
        end
        hour_beats.valid         <= 1'b1;
        hour_beats.hour          <= h;
        hour_beats.load          <= l;
        hour_beats.price         <= p;
        hour_beats.reward        <= r;
        hour_beats.explore       <= e;
        hour_beats.random_action <= a;
        offered++;
        do @(posedge clk); while (!hour_beats.ready);
    endtask

    // stop sending and wait for every predicted result
    task automatic drain();
        hour_beats.valid <= 1'b0;
        do @(posedge clk); while (awaited != 0);
    endtask

    // all three registers plus the spare index, one write per cycle
    task automatic set_registers(input logic [tqla_pkg::CFG_W-1:0] lr,
                                 input logic [tqla_pkg::CFG_W-1:0] dc,
                                 input logic [tqla_pkg::CFG_W-1:0] tm);
        cfg_we    <= 1'b1;
        cfg_idx   <= tqla_pkg::CFG_LEARNING_RATE;
        cfg_wdata <= lr;
        @(posedge clk);
        cfg_idx   <= tqla_pkg::CFG_DISCOUNT;
        cfg_wdata <= dc;
        @(posedge clk);
        cfg_idx   <= tqla_pkg::CFG_TIE_MARGIN;
        cfg_wdata <= tm;
        @(posedge clk);
        cfg_idx   <= CFG_SPARE;
        cfg_wdata <= tqla_pkg::CFG_W'($urandom);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin : stimulus
        int                                   lo;
        int                                   hi;
        logic [tqla_pkg::HOUR_W-1:0]          hr;
        logic [tqla_pkg::LOAD_W-1:0]          ld;
        logic [tqla_pkg::PRICE_W-1:0]         pr;
        logic signed [tqla_pkg::REWARD_W-1:0] rw;

        rst_n                    = 1'b0;
        cfg_we                   = 1'b0;
        cfg_idx                  = tqla_pkg::CFG_LEARNING_RATE;
        cfg_wdata                = '0;
        steady                   = 1'b0;
        offered                  = 0;
        hour_beats.valid         = 1'b0;
        hour_beats.hour          = '0;
        hour_beats.load          = '0;
        hour_beats.price         = '0;
        hour_beats.reward        = '0;
        hour_beats.explore       = 1'b0;
        hour_beats.random_action = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // band edges, reward extremes, wrapped random action, off-grid bins and spare hours
        offer(5'd0,  18'd64000,  15'd0,     32'sh7FFFFFFF, 1'b0, 2'd0);
        offer(5'd0,  18'd79984,  15'd1280,  32'sh80000000, 1'b0, 2'd0);
        offer(5'd1,  18'd79985,  15'd1281,  32'sd65536,    1'b1, 2'd2);
        offer(5'd1,  18'd95984,  15'd2560,  -32'sd65536,   1'b1, 2'd3);
        offer(5'd2,  18'd95985,  15'd2561,  32'sd1,        1'b0, 2'd1);
        offer(5'd2,  18'd111984, 15'd3840,  32'sd131072,   1'b0, 2'd0);
        offer(5'd3,  18'd111985, 15'd3841,  -32'sd1,       1'b1, 2'd1);
        offer(5'd3,  18'd136000, 15'd5120,  32'sd98304,    1'b0, 2'd2);
        offer(5'd4,  18'd100000, 15'd5121,  32'sd4096,     1'b0, 2'd0);
        offer(5'd4,  18'd100000, 15'd6400,  -32'sd70000,   1'b0, 2'd0);
        offer(5'd5,  18'd70000,  15'd12800, 32'sd200000,   1'b1, 2'd0);
        offer(5'd5,  18'd70000,  15'd15360, 32'sd65,       1'b0, 2'd3);
        offer(5'd6,  18'd70000,  15'd15361, 32'sd66,       1'b0, 2'd1);
        offer(5'd6,  18'd70000,  15'd17920, 32'sd67,       1'b1, 2'd1);
        offer(5'd7,  18'd63999,  15'd1000,  32'sd65536,    1'b0, 2'd0);
        offer(5'd7,  18'd136001, 15'd1000,  32'sd65536,    1'b0, 2'd0);
        offer(5'd7,  18'h3FFFF,  15'h7FFF,  32'sd65536,    1'b1, 2'd2);
        offer(5'd8,  18'd70000,  15'd6401,  32'sd65536,    1'b0, 2'd0);
        offer(5'd8,  18'd0,      15'd12799, 32'sd65536,    1'b0, 2'd0);
        offer(5'd8,  18'd70000,  15'd17921, 32'sd65536,    1'b0, 2'd0);
        offer(5'd24, 18'd70000,  15'd1000,  32'sd65536,    1'b0, 2'd0);
        offer(5'd31, 18'h3FFFF,  15'h7FFF,  -32'sd1,       1'b1, 2'd3);
        offer(5'd23, 18'd120000, 15'd16000, 32'sh40000000, 1'b0, 2'd0);
        offer(5'd23, 18'd120000, 15'd16000, 32'sh7FFFFFFF, 1'b0, 2'd0);
        offer(5'd0,  18'd64000,  15'd0,     -32'sd327680,  1'b1, 2'd3);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            case (ph)
                0: set_registers(16'hFFFF, 16'hFFFF, 16'h0000);
                1: set_registers(16'h0000, 16'h0000, 16'hFFFF);
                3: set_registers(16'd1, 16'd32768, 16'd66);
                default: set_registers(tqla_pkg::CFG_W'($urandom), tqla_pkg::CFG_W'($urandom),
                                       tqla_pkg::CFG_W'($urandom_range(0, 4095)));
            endcase
            // one whole phase with no idling on either side
            steady <= (ph == 2);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // mostly a few hours so values build up, some spare hours
                case ($urandom_range(0, 19))
                    0:       hr = tqla_pkg::HOUR_W'($urandom_range(24, 31));
                    1, 2, 3: hr = tqla_pkg::HOUR_W'($urandom_range(0, 23));
                    default: hr = tqla_pkg::HOUR_W'($urandom_range(0, 3));
                endcase
                // load inside a band, at its edges, or anywhere
                case ($urandom_range(0, 3))
                    0:
                    begin
                        lo = 64000;
                        hi = 79984;
                    end
                    1:
                    begin
                        lo = 79985;
                        hi = 95984;
                    end
                    2:
                    begin
                        lo = 95985;
                        hi = 111984;
                    end
                    default:
                    begin
                        lo = 111985;
                        hi = 136000;
                    end
                endcase
                case ($urandom_range(0, 9))
                    0:       ld = tqla_pkg::LOAD_W'($urandom);
                    1:       ld = tqla_pkg::LOAD_W'(lo);
                    2:       ld = tqla_pkg::LOAD_W'(hi);
                    default: ld = tqla_pkg::LOAD_W'($urandom_range(hi, lo));
                endcase
                // price likewise over its seven bands
                case ($urandom_range(0, 6))
                    0:
                    begin
                        lo = 0;
                        hi = 1280;
                    end
                    1:
                    begin
                        lo = 1281;
                        hi = 2560;
                    end
                    2:
                    begin
                        lo = 2561;
                        hi = 3840;
                    end
                    3:
                    begin
                        lo = 3841;
                        hi = 5120;
                    end
                    4:
                    begin
                        lo = 5121;
                        hi = 6400;
                    end
                    5:
                    begin
                        lo = 12800;
                        hi = 15360;
                    end
                    default:
                    begin
                        lo = 15361;
                        hi = 17920;
                    end
                endcase
                case ($urandom_range(0, 9))
                    0:       pr = tqla_pkg::PRICE_W'($urandom);
                    1:       pr = tqla_pkg::PRICE_W'(lo);
                    2:       pr = tqla_pkg::PRICE_W'(hi);
                    default: pr = tqla_pkg::PRICE_W'($urandom_range(hi, lo));
                endcase
                // small rewards mostly, with full-range and saturating ones
                case ($urandom_range(0, 9))
                    0:       rw = $urandom;
                    1:       rw = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
                    default: rw = $signed($urandom_range(0, 20 * 65536)) - 10 * 65536;
                endcase
                offer(hr, ld, pr, rw, $urandom_range(0, 99) < 30,
                      tqla_pkg::RAND_W'($urandom_range(0, 3)));
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("%0d hour beats over %0d register settings, edges and extremes included",
                 offered, PHASES + 1);
        $display("greedy and exploring picks, off-grid bins, spare hours and saturation");
        if (mismatches == 0 && awaited == 0)
            $display("tb_tabular_q_learning_agent: PASS");
        else
            $display("tb_tabular_q_learning_agent: FAIL");
        $finish;
    end

endmodule
